@@ hw/rtl/btdp_pkg.sv @@
// shared types and constants for the box table direction probe
package btdp_pkg;

   // request function codes
   typedef enum logic [2:0] {
      FN_ADD     = 3'd0,
      FN_REMOVE  = 3'd1,
      FN_CLEAR   = 3'd2,
      FN_RAY     = 3'd3,
      FN_CONTACT = 3'd4
   } func_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN,
      ST_RESP
   } state_type;

   localparam int COORD_W  = 16;
   localparam int SIZE_W   = 12;
   localparam int SPAN_W   = 19;
   localparam int SLOT_IDX_W = 8;
   localparam int DIRS     = 4;

   // one stored box
   typedef struct packed {
      logic [7:0]               id;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [SIZE_W-1:0]         size;
      logic                      blk;
      logic                      dmg;
      logic [7:0]                damage;
      logic [7:0]                owner;
   } entry_type;

   // overlap unit result: per direction step window, per axis overlap
   typedef struct packed {
      logic [DIRS-1:0][SPAN_W-1:0] lo;
      logic [DIRS-1:0][SPAN_W-1:0] hi;
      logic                        x_ok;
      logic                        y_ok;
   } ovl_type;

   // table update controls
   typedef struct packed {
      logic                  clr_all;
      logic                  clr_one;
      logic [SLOT_IDX_W-1:0] clr_idx;
      logic                  wr_en;
      logic [SLOT_IDX_W-1:0] wr_idx;
      entry_type             wr_entry;
   } store_ctl_type;

endpackage

@@ hw/rtl/btdp_ifs.sv @@
// channel interfaces for requests, responses and the config register
interface btdp_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        func;
   logic [7:0]        pawn_id;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [11:0]       box_size;
   logic              is_blocking;
   logic              does_damage;
   logic [7:0]        damage_amount;
   logic [7:0]        owner_id;
   logic              takes_damage;
   logic [7:0]        reach;
   modport source (output valid, func, pawn_id, pos_x, pos_y, box_size, is_blocking,
                   does_damage, damage_amount, owner_id, takes_damage, reach,
                   input ready);
   modport sink (input valid, func, pawn_id, pos_x, pos_y, box_size, is_blocking,
                 does_damage, damage_amount, owner_id, takes_damage, reach,
                 output ready);
endinterface

interface btdp_rsp_if;
   logic        valid;
   logic        ready;
   logic        left_blocked;
   logic        right_blocked;
   logic        up_blocked;
   logic        down_blocked;
   logic [7:0]  left_steps;
   logic [7:0]  right_steps;
   logic [7:0]  up_steps;
   logic [7:0]  down_steps;
   logic [15:0] damage_total;
   logic        status;
   modport source (output valid, left_blocked, right_blocked, up_blocked, down_blocked,
                   left_steps, right_steps, up_steps, down_steps, damage_total,
                   status, input ready);
   modport sink (input valid, left_blocked, right_blocked, up_blocked, down_blocked,
                 left_steps, right_steps, up_steps, down_steps, damage_total,
                 status, output ready);
endinterface

interface btdp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] contact_offset;
   modport source (output valid, contact_offset, input ready);
   modport sink (input valid, contact_offset, output ready);
endinterface

@@ hw/rtl/btdp_overlap.sv @@
// shared overlap unit: step windows of one stored box against the caller box
module btdp_overlap
   import btdp_pkg::*;
(
   input  logic signed [COORD_W-1:0] px,
   input  logic signed [COORD_W-1:0] py,
   input  logic [SIZE_W-1:0]         size,
   input  entry_type                 ent,
   output ovl_type                   ovl
);
   logic signed [COORD_W:0] dx;
   logic signed [COORD_W:0] dy;
   logic [COORD_W:0]        adx;
   logic [COORD_W:0]        ady;
   logic [SIZE_W:0]         sum;
   logic [SIZE_W-1:0]       half;
   logic signed [SPAN_W-1:0] h_s;
   logic signed [SPAN_W-1:0] d_s [DIRS];

   // distances, half of the size sum and axis overlap
   always_comb begin
      dx   = (COORD_W+1)'(px) - (COORD_W+1)'(ent.x);
      dy   = (COORD_W+1)'(py) - (COORD_W+1)'(ent.y);
      adx  = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
      ady  = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
      sum  = (SIZE_W+1)'(size) + (SIZE_W+1)'(ent.size);
      half = sum[SIZE_W:1];
      h_s  = SPAN_W'(half);
      d_s[0] = SPAN_W'(dx);
      d_s[1] = -SPAN_W'(dx);
      d_s[2] = SPAN_W'(dy);
      d_s[3] = -SPAN_W'(dy);
      ovl.x_ok = adx <= (COORD_W+1)'(half);
      ovl.y_ok = ady <= (COORD_W+1)'(half);
      for (int d = 0; d < DIRS; d++) begin
         ovl.lo[d] = d_s[d] - h_s;
         ovl.hi[d] = d_s[d] + h_s;
      end
   end
endmodule

@@ hw/rtl/btdp_slot_store.sv @@
// box table: valid flags in flops, box fields in a registered-read memory
module btdp_slot_store
   import btdp_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)(
   input  logic                           clock,
   input  logic                           reset,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
   output entry_type                      rd_entry,
   output logic [TABLE_DEPTH-1:0]         valid,
   input  store_ctl_type                  ctl
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [TABLE_DEPTH-1:0] valid_ff;
   entry_type              slot_mem_ff [TABLE_DEPTH];
   entry_type              rd_entry_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clr_all) begin
         valid_ff <= '0;
      end else begin
         if (ctl.clr_one) valid_ff[ctl.clr_idx[IDX_W-1:0]] <= 1'b0;
         if (ctl.wr_en)   valid_ff[ctl.wr_idx[IDX_W-1:0]]  <= 1'b1;
      end
   end

   // field memory
   always_ff @(posedge clock) begin
      if (ctl.wr_en) slot_mem_ff[ctl.wr_idx[IDX_W-1:0]] <= ctl.wr_entry;
      rd_entry_ff <= slot_mem_ff[rd_idx];
   end

   assign rd_entry = rd_entry_ff;
   assign valid    = valid_ff;
endmodule

@@ hw/rtl/box_table_direction_probe.sv @@
// box table with directional ray and contact probes, top level
// add, remove, ray and contact scan every table entry before the response; clear and
// unknown functions skip the scan
// one request at a time, a new one accepted only in idle; the scan reads one
// table entry per cycle through the shared overlap unit
// reset: synchronous, empties the table and sets contact_offset to 5; no clearing pass
module box_table_direction_probe
   import btdp_pkg::*;
#(
   parameter int TABLE_DEPTH = 32,
   parameter int MAX_REACH   = 255
)(
   input logic        clock,
   input logic        reset,
   btdp_req_if.sink   req_ch,
   btdp_rsp_if.source rsp_ch,
   btdp_csr_if.sink   csr_ch
);
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [11:0] MAX_REACH_W = 12'(MAX_REACH);

   state_type state_ff, state_in;
   logic [2:0] func_ff, func_in;
   logic [7:0] pid_ff, pid_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   entry_type new_ff, new_in;
   logic takes_ff, takes_in;
   logic [7:0] reach_ff, reach_in;
   logic [7:0] offset_ff, offset_in;
   logic [IDX_W-1:0] idx_ff, idx_in, p_idx_ff, p_idx_in;
   logic issue_ff, issue_in, p_vld_ff, p_vld_in;
   logic [DIRS-1:0] blk_ff, blk_in;
   logic [7:0] steps_ff [DIRS];
   logic [7:0] steps_in [DIRS];
   logic [15:0] total_ff, total_in;
   logic status_ff, status_in;
   logic match_ff, match_in, free_ff, free_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DIRS-1:0] rsp_blk_ff, rsp_blk_in;
   logic [7:0] rsp_steps_ff [DIRS];
   logic [7:0] rsp_steps_in [DIRS];
   logic [15:0] rsp_total_ff, rsp_total_in;
   logic rsp_status_ff, rsp_status_in;

   entry_type rd_entry;
   logic [TABLE_DEPTH-1:0] valid;
   store_ctl_type ctl;
   ovl_type ovl;

   logic req_fire;
   logic [7:0] reach_eff;
   logic ent_vld, same_id, ovl0;
   logic [16:0] dmg_sum;
   logic signed [SPAN_W-1:0] lo_s, hi_s, cand_s, off_s, reach_s;
   logic perp, ray_hit, con_hit;

   btdp_slot_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .rd_entry (rd_entry),
      .valid    (valid),
      .ctl      (ctl)
   );

   btdp_overlap u_overlap (
      .px   (px_ff),
      .py   (py_ff),
      .size (size_ff),
      .ent  (rd_entry),
      .ovl  (ovl)
   );

   // handshakes and response port
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.left_blocked  = rsp_blk_ff[0];
   assign rsp_ch.right_blocked = rsp_blk_ff[1];
   assign rsp_ch.up_blocked    = rsp_blk_ff[2];
   assign rsp_ch.down_blocked  = rsp_blk_ff[3];
   assign rsp_ch.left_steps    = rsp_steps_ff[0];
   assign rsp_ch.right_steps   = rsp_steps_ff[1];
   assign rsp_ch.up_steps      = rsp_steps_ff[2];
   assign rsp_ch.down_steps    = rsp_steps_ff[3];
   assign rsp_ch.damage_total  = rsp_total_ff;
   assign rsp_ch.status        = rsp_status_ff;

   // reach clamp
   assign reach_eff = ({4'b0, req_ch.reach} > MAX_REACH_W) ? MAX_REACH_W[7:0]
                                                           : req_ch.reach;

   // control state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         offset_ff    <= 8'd5;
         issue_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         issue_ff     <= issue_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and accumulator registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      pid_ff        <= pid_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      size_ff       <= size_in;
      new_ff        <= new_in;
      takes_ff      <= takes_in;
      reach_ff      <= reach_in;
      idx_ff        <= idx_in;
      p_idx_ff      <= p_idx_in;
      blk_ff        <= blk_in;
      steps_ff      <= steps_in;
      total_ff      <= total_in;
      status_ff     <= status_in;
      match_ff      <= match_in;
      free_ff       <= free_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_steps_ff  <= rsp_steps_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sequencer: next state, scan datapath and outputs
   always_comb begin
      state_in = state_ff;
      func_in = func_ff; pid_in = pid_ff; px_in = px_ff; py_in = py_ff;
      size_in = size_ff; new_in = new_ff; takes_in = takes_ff; reach_in = reach_ff;
      offset_in = offset_ff;
      idx_in = idx_ff; issue_in = issue_ff;
      p_idx_in = idx_ff; p_vld_in = 1'b0;
      blk_in = blk_ff; steps_in = steps_ff; total_in = total_ff; status_in = status_ff;
      match_in = match_ff; free_in = free_ff;
      match_idx_in = match_idx_ff; free_idx_in = free_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_blk_in = rsp_blk_ff; rsp_steps_in = rsp_steps_ff;
      rsp_total_in = rsp_total_ff; rsp_status_in = rsp_status_ff;
      ctl = '0;
      ctl.wr_entry = new_ff;
      ent_vld = valid[p_idx_ff];
      same_id = rd_entry.id == pid_ff;
      ovl0 = ovl.x_ok && ovl.y_ok;
      dmg_sum = 17'(total_ff) + 17'(rd_entry.damage);
      off_s = SPAN_W'(offset_ff);
      reach_s = SPAN_W'(reach_ff);
      lo_s = '0; hi_s = '0; cand_s = '0; perp = 1'b0; ray_hit = 1'b0; con_hit = 1'b0;

      if (csr_ch.valid) offset_in = csr_ch.contact_offset;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = req_ch.func;
               pid_in   = req_ch.pawn_id;
               px_in    = req_ch.pos_x;
               py_in    = req_ch.pos_y;
               size_in  = req_ch.box_size;
               takes_in = req_ch.takes_damage;
               reach_in = reach_eff;
               new_in.id     = req_ch.pawn_id;
               new_in.x      = req_ch.pos_x;
               new_in.y      = req_ch.pos_y;
               new_in.size   = req_ch.box_size;
               new_in.blk    = req_ch.is_blocking;
               new_in.dmg    = req_ch.does_damage;
               new_in.damage = req_ch.damage_amount;
               new_in.owner  = req_ch.owner_id;
               blk_in = '0; total_in = '0; status_in = 1'b0;
               match_in = 1'b0; free_in = 1'b0;
               for (int d = 0; d < DIRS; d++)
                  steps_in[d] = (req_ch.func == FN_RAY) ? reach_eff : 8'd0;
               idx_in = '0;
               if (req_ch.func == FN_ADD || req_ch.func == FN_REMOVE ||
                   req_ch.func == FN_RAY || req_ch.func == FN_CONTACT) begin
                  issue_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  ctl.clr_all = (req_ch.func == FN_CLEAR);
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            // issue side: one table read per cycle
            p_vld_in = issue_ff;
            if (issue_ff) begin
               if (idx_ff == LAST_IDX) issue_in = 1'b0;
               else idx_in = idx_ff + 1'b1;
            end
            // evaluate side: one entry per cycle
            if (p_vld_ff) begin
               case (func_ff)
                  FN_ADD: begin
                     if (ent_vld && same_id && !match_ff) begin
                        match_in = 1'b1; match_idx_in = p_idx_ff;
                     end
                     if (!ent_vld && !free_ff) begin
                        free_in = 1'b1; free_idx_in = p_idx_ff;
                     end
                  end
                  FN_REMOVE: begin
                     if (ent_vld && same_id) begin
                        ctl.clr_one = 1'b1;
                        ctl.clr_idx = SLOT_IDX_W'(p_idx_ff);
                     end
                  end
                  FN_RAY: begin
                     if (ent_vld && !same_id && rd_entry.blk) begin
                        for (int d = 0; d < DIRS; d++) begin
                           lo_s = $signed(ovl.lo[d]);
                           hi_s = $signed(ovl.hi[d]);
                           perp = (d < 2) ? ovl.y_ok : ovl.x_ok;
                           cand_s = lo_s[SPAN_W-1] ? '0 : lo_s;
                           ray_hit = perp && cand_s <= hi_s && cand_s < reach_s;
                           if (ray_hit) begin
                              blk_in[d] = 1'b1;
                              if (cand_s[7:0] < steps_in[d]) steps_in[d] = cand_s[7:0];
                           end
                        end
                     end
                  end
                  FN_CONTACT: begin
                     if (ent_vld && !same_id) begin
                        if (rd_entry.dmg && takes_ff && rd_entry.owner != pid_ff &&
                            ovl0) begin
                           total_in = dmg_sum[16] ? 16'hFFFF : dmg_sum[15:0];
                           ctl.clr_one = 1'b1;
                           ctl.clr_idx = SLOT_IDX_W'(p_idx_ff);
                        end else if (rd_entry.blk) begin
                           for (int d = 0; d < DIRS; d++) begin
                              lo_s = $signed(ovl.lo[d]);
                              hi_s = $signed(ovl.hi[d]);
                              perp = (d < 2) ? ovl.y_ok : ovl.x_ok;
                              con_hit = perp && lo_s <= off_s && off_s <= hi_s;
                              if (con_hit) blk_in[d] = 1'b1;
                           end
                        end
                     end
                  end
                  default: ;
               endcase
               if (p_idx_ff == LAST_IDX) state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // add commits to the matching slot, else the lowest free one
            if (func_ff == FN_ADD) begin
               if (match_ff) begin
                  ctl.wr_en = 1'b1;
                  ctl.wr_idx = SLOT_IDX_W'(match_idx_ff);
               end else if (free_ff) begin
                  ctl.wr_en = 1'b1;
                  ctl.wr_idx = SLOT_IDX_W'(free_idx_ff);
               end else begin
                  status_in = 1'b1;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_blk_in = blk_ff;
               rsp_steps_in = steps_ff;
               rsp_total_in = total_ff;
               rsp_status_in = status_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   // scan evaluates consecutive entries
   assert property (@(posedge clock) disable iff (reset)
      p_vld_ff && $past(p_vld_ff) |-> p_idx_ff == $past(p_idx_ff) + 1'b1)
      else $error("scan index skipped");

   // scan pipeline drained when committing
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> !issue_ff && !p_vld_ff)
      else $error("scan still active at commit");

   // reported steps never exceed the reach
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN |-> steps_ff[0] <= reach_ff && steps_ff[1] <= reach_ff &&
                             steps_ff[2] <= reach_ff && steps_ff[3] <= reach_ff)
      else $error("step beyond reach");

   // a dropped add leaves the table untouched
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && func_ff == FN_ADD && !match_ff && !free_ff |=>
      $stable(valid))
      else $error("dropped add changed table");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the box table direction probe
module tb_top;
   import btdp_pkg::*;

   localparam int DEPTH       = 32;
   localparam int RSP_LATENCY = DEPTH + 4;
   localparam int IDLE_LIMIT  = 3000;
   localparam int HOLD_CYCLES = 400;

   // one request beat as the predictor sees it
   typedef struct {
      logic [2:0]         func;
      logic [7:0]         pawn_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [11:0]        box_size;
      logic               is_blocking;
      logic               does_damage;
      logic [7:0]         damage_amount;
      logic [7:0]         owner_id;
      logic               takes_damage;
      logic [7:0]         reach;
   } probe_req_type;

   // one response beat, directions ordered left, right, up, down
   typedef struct {
      logic [3:0]       blocked;
      logic [7:0]       steps [4];
      logic [15:0]      damage;
      logic             status;
   } probe_rsp_type;

   logic clock;
   logic reset;

   btdp_req_if req_if ();
   btdp_rsp_if rsp_if ();
   btdp_csr_if csr_if ();

   box_table_direction_probe dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predictor copy of the box table and the offset register
   bit         box_used [DEPTH];
   entry_type  box_tbl  [DEPTH];
   logic [7:0] offset_reg = 8'd5;

   probe_rsp_type pending_rsp [$];
   int         fail_count = 0;
   bit         idle_on = 1'b1;
   bit         hold_start = 1'b0;
   bit         hold_active = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overlap test on doubled distances, exact integers
   function automatic bit boxes_touch(longint x, longint y, longint sz, int k);
      longint dx, dy, sum;
      dx = x - longint'(box_tbl[k].x);
      dy = y - longint'(box_tbl[k].y);
      sum = sz + longint'(box_tbl[k].size);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return (dx * 2 <= sum) && (dy * 2 <= sum);
   endfunction

   // expected response for one accepted request, updates the table copy
   function automatic probe_rsp_type predict_probe(probe_req_type r);
      probe_rsp_type e;
      int         target;
      longint     x, y, off;
      int         total;
      e.blocked = '0;
      e.damage = '0;
      e.status = 1'b0;
      for (int d = 0; d < 4; d++) e.steps[d] = '0;
      total = 0;
      target = -1;
      case (r.func)
         FN_ADD: begin
            for (int k = 0; k < DEPTH && target < 0; k++)
               if (box_used[k] && box_tbl[k].id == r.pawn_id) target = k;
            for (int k = 0; k < DEPTH && target < 0; k++)
               if (!box_used[k]) target = k;
            if (target < 0) begin
               e.status = 1'b1;
            end else begin
               box_used[target] = 1'b1;
               box_tbl[target].id = r.pawn_id;
               box_tbl[target].x = r.pos_x;
               box_tbl[target].y = r.pos_y;
               box_tbl[target].size = r.box_size;
               box_tbl[target].blk = r.is_blocking;
               box_tbl[target].dmg = r.does_damage;
               box_tbl[target].damage = r.damage_amount;
               box_tbl[target].owner = r.owner_id;
            end
         end
         FN_REMOVE: begin
            for (int k = 0; k < DEPTH; k++)
               if (box_used[k] && box_tbl[k].id == r.pawn_id) box_used[k] = 1'b0;
         end
         FN_CLEAR: begin
            for (int k = 0; k < DEPTH; k++) box_used[k] = 1'b0;
         end
         FN_RAY: begin
            // first step per direction at which a foreign blocking box overlaps
            for (int d = 0; d < 4; d++) e.steps[d] = r.reach;
            for (int s = 0; s < r.reach; s++)
               for (int k = 0; k < DEPTH; k++) begin
                  if (!box_used[k] || box_tbl[k].id == r.pawn_id || !box_tbl[k].blk) continue;
                  for (int d = 0; d < 4; d++) begin
                     if (e.blocked[d]) continue;
                     x = r.pos_x;
                     y = r.pos_y;
                     case (d)
                        0: x = x - s;
                        1: x = x + s;
                        2: y = y - s;
                        default: y = y + s;
                     endcase
                     if (boxes_touch(x, y, r.box_size, k)) begin
                        e.blocked[d] = 1'b1;
                        e.steps[d] = s[7:0];
                     end
                  end
               end
         end
         FN_CONTACT: begin
            // damaging boxes are eaten first, the rest block at the offset
            off = offset_reg;
            for (int k = 0; k < DEPTH; k++) begin
               if (!box_used[k] || box_tbl[k].id == r.pawn_id) continue;
               if (box_tbl[k].dmg && r.takes_damage && box_tbl[k].owner != r.pawn_id &&
                   boxes_touch(r.pos_x, r.pos_y, r.box_size, k)) begin
                  total = total + box_tbl[k].damage;
                  if (total > 65535) total = 65535;
                  box_used[k] = 1'b0;
                  continue;
               end
               if (!box_tbl[k].blk) continue;
               if (boxes_touch(longint'(r.pos_x) - off, r.pos_y, r.box_size, k))
                  e.blocked[0] = 1'b1;
               if (boxes_touch(longint'(r.pos_x) + off, r.pos_y, r.box_size, k))
                  e.blocked[1] = 1'b1;
               if (boxes_touch(r.pos_x, longint'(r.pos_y) - off, r.box_size, k))
                  e.blocked[2] = 1'b1;
               if (boxes_touch(r.pos_x, longint'(r.pos_y) + off, r.box_size, k))
                  e.blocked[3] = 1'b1;
            end
            e.damage = total[15:0];
         end
         default: ;
      endcase
      return e;
   endfunction

   // mismatch report, one line each
   task automatic report_mismatch(string what, longint got, longint want);
      fail_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   // compare one response beat against the oldest expectation
   task automatic check_response();
      probe_rsp_type e;
      if (pending_rsp.size() == 0) begin
         report_mismatch("unexpected response beat", 1, 0);
         return;
      end
      e = pending_rsp.pop_front();
      if (rsp_if.left_blocked !== e.blocked[0])
         report_mismatch("left_blocked", rsp_if.left_blocked, e.blocked[0]);
      if (rsp_if.right_blocked !== e.blocked[1])
         report_mismatch("right_blocked", rsp_if.right_blocked, e.blocked[1]);
      if (rsp_if.up_blocked !== e.blocked[2])
         report_mismatch("up_blocked", rsp_if.up_blocked, e.blocked[2]);
      if (rsp_if.down_blocked !== e.blocked[3])
         report_mismatch("down_blocked", rsp_if.down_blocked, e.blocked[3]);
      if (rsp_if.left_steps !== e.steps[0])
         report_mismatch("left_steps", rsp_if.left_steps, e.steps[0]);
      if (rsp_if.right_steps !== e.steps[1])
         report_mismatch("right_steps", rsp_if.right_steps, e.steps[1]);
      if (rsp_if.up_steps !== e.steps[2])
         report_mismatch("up_steps", rsp_if.up_steps, e.steps[2]);
      if (rsp_if.down_steps !== e.steps[3])
         report_mismatch("down_steps", rsp_if.down_steps, e.steps[3]);
      if (rsp_if.damage_total !== e.damage)
         report_mismatch("damage_total", rsp_if.damage_total, e.damage);
      if (rsp_if.status !== e.status)
         report_mismatch("status", rsp_if.status, e.status);
   endtask

   // response side: check accepted beats, stall in random bursts
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_response();
         if (stall_left > 0) stall_left--;
         else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 18);
         rsp_if.ready <= !hold_active && (stall_left == 0);
      end
   end

   // long receiver hold-off, counted here, started by a toggle of hold_start
   initial begin
      int hold_left;
      bit hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start != hold_seen) begin
            hold_seen = hold_start;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            hold_active <= 1'b1;
         end else begin
            hold_active <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no beat accepted anywhere
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
             (csr_if.valid === 1'b1 && csr_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
         if (quiet >= IDLE_LIMIT) begin
            $display("** box_table_direction_probe: FAILED **");
            $finish;
         end
      end
   end

   // send one request beat, predict at accept, maybe idle afterwards
   task automatic send_probe(probe_req_type r);
      int gap;
      req_if.valid <= 1'b1;
      req_if.func <= r.func;
      req_if.pawn_id <= r.pawn_id;
      req_if.pos_x <= r.pos_x;
      req_if.pos_y <= r.pos_y;
      req_if.box_size <= r.box_size;
      req_if.is_blocking <= r.is_blocking;
      req_if.does_damage <= r.does_damage;
      req_if.damage_amount <= r.damage_amount;
      req_if.owner_id <= r.owner_id;
      req_if.takes_damage <= r.takes_damage;
      req_if.reach <= r.reach;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_rsp.insert(pending_rsp.size(), predict_probe(r));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops until every expected beat has come back
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   // write the contact offset while the block is idle
   task automatic write_offset(logic [7:0] value);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.contact_offset <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      csr_if.valid <= 1'b0;
      offset_reg = value;
   endtask

   function automatic probe_req_type make_probe(logic [2:0] func, int id,
         int x, int y, int sz, int blk, int dmg, int amt, int owner, int takes, int reach);
      probe_req_type r;
      r.func = func;
      r.pawn_id = id[7:0];
      r.pos_x = x[15:0];
      r.pos_y = y[15:0];
      r.box_size = sz[11:0];
      r.is_blocking = blk[0];
      r.does_damage = dmg[0];
      r.damage_amount = amt[7:0];
      r.owner_id = owner[7:0];
      r.takes_damage = takes[0];
      r.reach = reach[7:0];
      return r;
   endfunction

   // random request: mostly a crowded neighborhood of a few dozen ids
   function automatic probe_req_type random_probe();
      probe_req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) r.func = FN_ADD;
      else if (pick < 45) r.func = FN_REMOVE;
      else if (pick < 47) r.func = FN_CLEAR;
      else if (pick < 74) r.func = FN_RAY;
      else if (pick < 97) r.func = FN_CONTACT;
      else r.func = 3'($urandom_range(5, 7));
      r.pawn_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
      if ($urandom_range(0, 9) == 0) begin
         r.pos_x = 16'($urandom);
         r.pos_y = 16'($urandom);
      end else begin
         r.pos_x = 16'(int'($urandom_range(0, 400)) - 200);
         r.pos_y = 16'(int'($urandom_range(0, 400)) - 200);
      end
      r.box_size = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 120));
      r.is_blocking = 1'($urandom);
      r.does_damage = 1'($urandom);
      r.damage_amount = 8'($urandom);
      r.owner_id = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 40));
      r.takes_damage = ($urandom_range(0, 3) != 0);
      r.reach = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 60));
      return r;
   endfunction

   // extremes, each function and the corner cases
   task automatic test_directed();
      send_probe(make_probe(FN_ADD, 0, -32768, -32768, 4095, 1, 1, 255, 255, 1, 0));
      send_probe(make_probe(FN_ADD, 255, 32767, 32767, 0, 0, 0, 0, 0, 0, 255));
      send_probe(make_probe(FN_RAY, 255, 32767, 32767, 4095, 0, 0, 0, 0, 0, 255));
      send_probe(make_probe(FN_RAY, 1, -32768, -32768, 4095, 0, 0, 0, 0, 0, 255));
      // present id rewritten in place
      send_probe(make_probe(FN_ADD, 0, 0, 0, 20, 1, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_ADD, 7, 30, 0, 10, 1, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_ADD, 8, 0, -40, 10, 1, 1, 100, 99, 0, 0));
      send_probe(make_probe(FN_RAY, 1, 0, 0, 10, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_RAY, 1, 0, 60, 10, 0, 0, 0, 0, 0, 255));
      send_probe(make_probe(FN_RAY, 200, 60, 0, 10, 0, 0, 0, 0, 0, 40));
      send_probe(make_probe(FN_RAY, 0, 0, 0, 20, 0, 0, 0, 0, 0, 50));
      // damaging box owned by another is eaten
      send_probe(make_probe(FN_CONTACT, 1, 0, -30, 10, 0, 0, 0, 0, 1, 0));
      send_probe(make_probe(FN_ADD, 9, 0, 0, 10, 1, 1, 50, 1, 0, 0));
      send_probe(make_probe(FN_CONTACT, 1, 0, 0, 10, 0, 0, 0, 0, 1, 0));
      send_probe(make_probe(FN_CONTACT, 2, 0, 0, 10, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_CONTACT, 2, 0, 0, 10, 0, 0, 0, 0, 1, 0));
      send_probe(make_probe(FN_REMOVE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_REMOVE, 77, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(3'd5, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      send_probe(make_probe(3'd6, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      send_probe(make_probe(3'd7, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1));
      send_probe(make_probe(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_RAY, 1, 0, 0, 4095, 0, 0, 0, 0, 0, 20));
   endtask

   // fill every slot, then one add too many
   task automatic test_table_full();
      for (int i = 0; i <= DEPTH; i++)
         send_probe(make_probe(FN_ADD, i, i * 8, 0, 6, 1, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_ADD, 3, 5, 5, 6, 1, 1, 9, 0, 0, 0));
      send_probe(make_probe(FN_RAY, 100, 0, 0, 4, 0, 0, 0, 0, 0, 30));
      send_probe(make_probe(FN_REMOVE, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_ADD, 200, 0, 20, 6, 1, 0, 0, 0, 0, 0));
      send_probe(make_probe(FN_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   // random probes, every second one a contact, under several offsets, extremes included
   task automatic test_offset_sweep();
      logic [7:0] offsets [4];
      probe_req_type r;
      offsets = '{8'd0, 8'd255, 8'd1, 8'($urandom)};
      foreach (offsets[i]) begin
         write_offset(offsets[i]);
         for (int n = 0; n < 24; n++) begin
            r = random_probe();
            if (n % 2 == 1) r.func = FN_CONTACT;
            send_probe(r);
         end
      end
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_receiver_holdoff();
      hold_start = !hold_start;
      for (int n = 0; n < 25; n++) send_probe(random_probe());
   endtask

   // sender pauses until the block has answered everything
   task automatic test_sender_pause();
      wait_drained();
      for (int n = 0; n < 10; n++) send_probe(random_probe());
   endtask

   // long random run, no idling in its last stretch
   task automatic test_random();
      for (int n = 0; n < 1500; n++) begin
         if (n == 1250) idle_on = 1'b0;
         send_probe(random_probe());
      end
   endtask

   initial begin
      // inputs known from the start
      req_if.valid <= 1'b0;
      req_if.func <= '0;
      req_if.pawn_id <= '0;
      req_if.pos_x <= '0;
      req_if.pos_y <= '0;
      req_if.box_size <= '0;
      req_if.is_blocking <= 1'b0;
      req_if.does_damage <= 1'b0;
      req_if.damage_amount <= '0;
      req_if.owner_id <= '0;
      req_if.takes_damage <= 1'b0;
      req_if.reach <= '0;
      csr_if.valid <= 1'b0;
      csr_if.contact_offset <= '0;
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_offset_sweep();
      test_receiver_holdoff();
      test_sender_pause();
      write_offset(8'd5);
      test_random();
      wait_drained();
      if (fail_count == 0)
         $display("** box_table_direction_probe: PASSED **");
      else
         $display("** box_table_direction_probe: FAILED **");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/btdp_pkg.sv
hw/rtl/btdp_ifs.sv
hw/rtl/btdp_overlap.sv
hw/rtl/btdp_slot_store.sv
hw/rtl/box_table_direction_probe.sv
tb/tb_top.sv
